[hw/rtl/b32e_pkg.sv]
// Shared types, constants and the character table of the base32 stream encoder.
`timescale 1ns / 1ps

package b32e_pkg;

  // Width of one base32 character index.
  localparam int unsigned CharBits = 5;
  // Bits kept in a classified job window.
  localparam int unsigned WindowBits = 12;
  // Width of a bit count in the range 0 to 12.
  localparam int unsigned CountBits = 4;
  // Padding character after reset.
  localparam logic [7:0] PadReset = 8'd61;

  // One input word: a message byte and its end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  // One output word: a character and its end-of-message flag.
  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_word_t;

  // A classified byte as it waits between front and back.
  typedef struct packed {
    logic [WindowBits-1:0] window;
    logic [CountBits-1:0]  nbits;
    logic                  last;
  } job_t;

  // Back-end control status per cycle.
  typedef struct packed {
    logic emit;
    logic pop;
  } b32e_ctl_t;

  // Maps a 5-bit index to its letter of the RFC 4648 alphabet.
  function automatic logic [7:0] b32_char(input logic [CharBits-1:0] idx);
    logic [7:0] code;
    if (idx < 5'd26) begin
      code = 8'h41 + {3'b000, idx};
    end else begin
      code = 8'h18 + {3'b000, idx};
    end
    return code;
  endfunction

endpackage

[hw/rtl/b32e_front.sv]
// Front end: accepts message bytes, keeps the leftover bits and classifies each byte as a job.
`timescale 1ns / 1ps

module b32e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  b32e_pkg::in_word_t in_word_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output b32e_pkg::job_t    job_o
);
  import b32e_pkg::*;

  logic [3:0]           bits_q, bits_d;
  logic [2:0]           held_q, held_d;
  logic [CountBits-1:0] nbits;
  logic [CountBits-1:0] rem;

  // A word is taken whenever the queue has room.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  // Append the byte below the leftover bits.
  assign nbits = {1'b0, held_q} + 4'd8;
  assign rem   = (nbits >= 4'd10) ? (nbits - 4'd10) : (nbits - 4'd5);

  assign job_o.window = {bits_q, in_word_i.data_byte};
  assign job_o.nbits  = nbits;
  assign job_o.last   = in_word_i.last_byte;

  // Leftover bits after the job's full characters; a message end clears them.
  always_comb begin
    bits_d = bits_q;
    held_d = held_q;
    if (push_o) begin
      if (in_word_i.last_byte) begin
        bits_d = '0;
        held_d = '0;
      end else begin
        bits_d = in_word_i.data_byte[3:0];
        held_d = rem[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
      held_q <= '0;
    end else begin
      bits_q <= bits_d;
      held_q <= held_d;
    end
  end

endmodule

[hw/rtl/b32e_queue.sv]
// Small job queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module b32e_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b32e_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output b32e_pkg::job_t head_o
);
  import b32e_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[hw/rtl/b32e_back.sv]
// Back end: turns the head job into characters, flushes and pads at message end.
`timescale 1ns / 1ps

module b32e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          pad_char_i,
  input  logic                head_valid_i,
  input  b32e_pkg::job_t      head_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output b32e_pkg::out_word_t out_word_o,
  output b32e_pkg::b32e_ctl_t ctl_o
);
  import b32e_pkg::*;

  logic                 started_q, started_d;
  logic [CountBits-1:0] held_q, held_d;
  logic [2:0]           gpos_q, gpos_d;
  logic                 valid_q, valid_d;
  out_word_t            word_q, word_d;

  logic                  advance;
  logic [CountBits-1:0]  held;
  logic [CountBits-1:0]  next_held;
  logic [2:0]            next_gpos;
  logic                  take_data;
  logic                  flush;
  logic [2:0]            shamt;
  logic [WindowBits-1:0] data_shift;
  logic [WindowBits+4:0] flush_shift;
  logic [CharBits-1:0]   idx;
  logic                  more;
  logic [7:0]            ch;

  // The output register moves when empty or when its word is taken.
  assign advance = ~valid_q | ~out_stall_i;

  // Bits left in the head job; a fresh job starts with all of them.
  assign held      = started_q ? held_q : head_i.nbits;
  assign take_data = (held >= 4'd5);
  assign flush     = ~take_data & head_i.last & (held != '0);

  // Character index: full character from the top of the held bits, or zero-filled tail.
  assign shamt       = 3'(held - 4'd5);
  assign data_shift  = head_i.window >> shamt;
  assign flush_shift = {head_i.window, 5'b00000} >> held;
  assign idx         = take_data ? data_shift[CharBits-1:0] : flush_shift[CharBits-1:0];
  assign ch          = (take_data || flush) ? b32_char(idx) : pad_char_i;

  // Decide whether this character ends the job.
  assign next_held = take_data ? (held - 4'd5) : '0;
  assign next_gpos = gpos_q + 3'd1;
  assign more = (next_held >= 4'd5)
              | (head_i.last & (next_held != '0))
              | (head_i.last & (pad_char_i != '0) & (next_gpos != '0));

  assign ctl_o.emit = head_valid_i & advance;
  assign ctl_o.pop  = head_valid_i & advance & ~more;

  // Sequencer and output register update.
  always_comb begin
    started_d = started_q;
    held_d    = held_q;
    gpos_d    = gpos_q;
    valid_d   = valid_q;
    word_d    = word_q;
    if (advance) begin
      valid_d = head_valid_i;
    end
    if (ctl_o.emit) begin
      word_d.out_char = ch;
      word_d.out_last = head_i.last & ~more;
      if (more) begin
        started_d = 1'b1;
        held_d    = next_held;
        gpos_d    = next_gpos;
      end else begin
        started_d = 1'b0;
        held_d    = '0;
        gpos_d    = head_i.last ? 3'd0 : next_gpos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      held_q    <= '0;
      gpos_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      started_q <= started_d;
      held_q    <= held_d;
      gpos_q    <= gpos_d;
      valid_q   <= valid_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

[hw/rtl/base32_stream_encoder.sv]
// Top level of the base32 stream encoder: front end, job queue, back end and pad register.
//
//   Channel   Direction  Handshake              Word
//   in        input      in_valid_i/in_stall_o  in_word_i  (data_byte, last_byte)
//   out       output     out_valid_o/out_stall_i out_word_o (out_char, out_last)
//   cfg       input      cfg_we_i               cfg_wdata_i (pad_char)
//
// The back end sends one character per cycle unless the output stalls, so a byte yields one or
// two characters (1.6 on average, eight per five bytes); a last byte yields up to eight.
// With an empty queue, an accepted byte passes the queue entry, then the output word register.
// Reset clears the queue and the leftover bits and sets the pad character to '='.
// A stalled output holds the back end; the queue of QueueDepth words absorbs input.
`timescale 1ns / 1ps

module base32_stream_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b32e_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b32e_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import b32e_pkg::*;

  logic      [7:0] pad_q;
  logic            q_full;
  logic            q_push;
  logic            q_valid;
  job_t            q_job;
  job_t            q_head;
  b32e_ctl_t       back_ctl;

  // Padding register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= PadReset;
    end else if (cfg_we_i) begin
      pad_q <= cfg_wdata_i;
    end
  end

  b32e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_stall_o (in_stall_o),
    .full_i     (q_full),
    .push_o     (q_push),
    .job_o      (q_job)
  );

  b32e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job),
    .pop_i   (back_ctl.pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  b32e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pad_char_i   (pad_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .ctl_o        (back_ctl)
  );

`ifndef SYNTHESIS
  // A job leaves the queue only together with a character it produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_ctl.pop |-> (back_ctl.emit && q_valid))
    else $error("job popped without a character");

  // Finishing a message job puts its final-flagged character on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_ctl.pop && q_head.last) |=> (out_valid_o && out_word_o.out_last))
    else $error("message end not flagged on output");

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("push into full queue");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the base32 stream encoder: directed table, then random messages.
`timescale 1ns / 1ps

module tb_top;
  import b32e_pkg::*;

  // Run limit in cycles, and the settle time after the last expected character.
  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned NumPhases = 6;
  localparam bit [255:0] Alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  // A table row either sends one input word or rewrites the pad character.
  typedef enum logic {
    RowWord,
    RowPad
  } row_kind_e;

  // Typed characters are right-justified; an all-zero field means the row is predicted.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  value;
    logic        last;
    logic [63:0] typed;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_word_t   in_word_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned recv_cycles = 0;
  int unsigned stall_left = 0;
  bit          calm_sender = 1'b0;

  out_word_t pending_chars[$];
  out_word_t head_char;
  stim_row_t stim_rows[$];

  // Encoder state as the predictor sees it.
  logic [11:0] enc_bits = '0;
  int          enc_held = 0;
  logic [2:0]  enc_pos = '0;
  logic [7:0]  enc_pad = PadReset;

  base32_stream_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("base32_stream_encoder regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Idle lengths: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [7:0] b32_letter(input logic [4:0] idx);
    return Alphabet[8 * (31 - int'(idx)) +: 8];
  endfunction

  // Predict the characters of one accepted word and advance the encoder state.
  task automatic encode_byte(input in_word_t w, input bit record);
    out_word_t   res[8];
    int          n;
    logic [11:0] shifted;
    n = 0;
    enc_bits = {enc_bits[3:0], w.data_byte};
    enc_held += 8;
    while (enc_held >= 5) begin
      shifted = enc_bits >> (enc_held - 5);
      enc_held -= 5;
      res[n] = '{out_char: b32_letter(shifted[4:0]), out_last: 1'b0};
      n++;
      enc_pos++;
    end
    if (w.last_byte) begin
      // Flush the partial character with zero fill, then pad out the group.
      if (enc_held != 0) begin
        shifted = enc_bits << (5 - enc_held);
        res[n] = '{out_char: b32_letter(shifted[4:0]), out_last: 1'b0};
        n++;
        enc_pos++;
      end
      if (enc_pad != 8'd0) begin
        while (enc_pos != 3'd0 && n < 8) begin
          res[n] = '{out_char: enc_pad, out_last: 1'b0};
          n++;
          enc_pos++;
        end
      end
      res[n - 1].out_last = 1'b1;
      enc_bits = '0;
      enc_held = 0;
      enc_pos = '0;
    end
    if (record) begin
      for (int k = 0; k < n; k++) begin
        pending_chars.push_back(res[k]);
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Send one word; on acceptance, queue its typed or predicted characters.
  task automatic send_word(input in_word_t w, input logic [63:0] typed);
    int unsigned gap;
    gap = 0;
    if (!calm_sender) begin
      // Occasionally hold off until every character in flight has come out.
      if ($urandom_range(0, 24) == 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      gap = pick_gap();
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      in_word_i <= {8'($urandom), 1'($urandom)};
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    if (typed != '0) begin
      encode_byte(w, 1'b0);
      for (int k = 7; k >= 0; k--) begin
        if (typed[8 * k +: 8] != 8'd0) begin
          pending_chars.push_back('{out_char: typed[8 * k +: 8],
                                    out_last: w.last_byte && (k == 0)});
        end
      end
    end else begin
      encode_byte(w, 1'b1);
    end
  endtask

  // Pad writes happen only with the input idle and no character outstanding.
  task automatic set_pad(input logic [7:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    enc_pad = value;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [7:0] value, input logic last,
                         input logic [63:0] typed);
    stim_rows.push_back('{kind: kind, value: value, last: last, typed: typed});
  endtask

  // Receiver stalls at random, with a calm stretch in every fourth window.
  always @(posedge clk_i) begin
    recv_cycles <= recv_cycles + 1;
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ((recv_cycles / 256) % 4 != 1 && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted output word with the oldest expected character.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %02h last %0b",
                                  out_word_o.out_char, out_word_o.out_last));
      end else begin
        head_char = pending_chars.pop_front();
        if (out_word_o.out_char !== head_char.out_char) begin
          report_mismatch($sformatf("out_char %02h, expected %02h",
                                    out_word_o.out_char, head_char.out_char));
        end
        if (out_word_o.out_last !== head_char.out_last) begin
          report_mismatch($sformatf("out_last %0b, expected %0b on char %02h",
                                    out_word_o.out_last, head_char.out_last,
                                    head_char.out_char));
        end
      end
    end
  end

  initial begin
    stim_row_t  row;
    in_word_t   w;
    int         msg_len;
    int         phase_bytes;
    int         r;
    logic [7:0] phase_pads[NumPhases];

    // Single-byte extremes under the reset pad character.
    add_row(RowWord, 8'h00, 1'b1, "AA======");
    add_row(RowWord, 8'hFF, 1'b1, "74======");
    // A six-byte message that crosses a group boundary.
    add_row(RowWord, 8'h66, 1'b0, "M");
    add_row(RowWord, 8'h6F, 1'b0, "ZX");
    add_row(RowWord, 8'h6F, 1'b0, "W");
    add_row(RowWord, 8'h62, 1'b0, "6Y");
    add_row(RowWord, 8'h61, 1'b0, "TB");
    add_row(RowWord, 8'h72, 1'b1, "OI======");
    // Five bytes fill the group exactly, so no padding follows.
    add_row(RowWord, 8'h66, 1'b0, "M");
    add_row(RowWord, 8'h6F, 1'b0, "ZX");
    add_row(RowWord, 8'h6F, 1'b0, "W");
    add_row(RowWord, 8'h62, 1'b0, "6Y");
    add_row(RowWord, 8'h61, 1'b1, "TB");
    // Two bytes: flush plus four pad characters.
    add_row(RowWord, 8'h66, 1'b0, "M");
    add_row(RowWord, 8'h6F, 1'b1, "ZXQ====");
    // Padding disabled: the message ends on the flushed character.
    add_row(RowPad, 8'h00, 1'b0, '0);
    add_row(RowWord, 8'h66, 1'b1, "MY");
    add_row(RowWord, 8'hFF, 1'b0, "7");
    add_row(RowWord, 8'h00, 1'b1, "4AA");
    // Unusual pad characters, top and bottom of the range.
    add_row(RowPad, 8'hFF, 1'b0, '0);
    add_row(RowWord, 8'h00, 1'b1, '0);
    add_row(RowPad, 8'h01, 1'b0, '0);
    add_row(RowWord, 8'hA5, 1'b1, '0);
    add_row(RowPad, PadReset, 1'b0, '0);

    phase_pads = '{8'h00, 8'hFF, PadReset, 8'h01, 8'($urandom_range(1, 254)),
                   8'($urandom_range(0, 255))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == RowPad) begin
        set_pad(row.value);
      end else begin
        w = '{data_byte: row.value, last_byte: row.last};
        send_word(w, row.typed);
      end
    end

    // Random whole messages, one pad setting per phase.
    for (int p = 0; p < NumPhases; p++) begin
      set_pad(phase_pads[p]);
      phase_bytes = 0;
      while (phase_bytes < 28) begin
        calm_sender = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 19);
        if (r < 14) begin
          msg_len = $urandom_range(1, 8);
        end else if (r < 19) begin
          msg_len = $urandom_range(9, 20);
        end else begin
          msg_len = $urandom_range(21, 40);
        end
        for (int i = 0; i < msg_len; i++) begin
          w = '{data_byte: 8'($urandom_range(0, 255)), last_byte: (i == msg_len - 1)};
          send_word(w, '0);
          phase_bytes++;
        end
      end
    end

    // Let every expected character come out, then settle.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("base32_stream_encoder regression: pass");
    end else begin
      $display("base32_stream_encoder regression: fail");
    end
    $finish;
  end

endmodule
